[hdl/apbd_pkg.sv]
// Shared types and constants for the PCM / 4-bit ADPCM block decoder.
package apbd_pkg;

  localparam int SAMPLES_PER_FRAME = 14;
  localparam int FPOS_W = $clog2(SAMPLES_PER_FRAME);
  localparam logic [FPOS_W-1:0] FPOS_LAST = FPOS_W'(SAMPLES_PER_FRAME - 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEFF_BANKS = 4;
  localparam int COEFFS_PER_BANK = 4;

  // Prediction arithmetic
  localparam int FRAC_BITS = 11;
  localparam int SUM_W = 34;
  localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(1024);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

  typedef enum logic [1:0] {
    FMT_PCM8  = 2'd0,
    FMT_PCM16 = 2'd1,
    FMT_ADPCM = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT      = 3'd0,
    REG_COEFF_BANK0 = 3'd1,
    REG_COEFF_BANK1 = 3'd2,
    REG_COEFF_BANK2 = 3'd3,
    REG_COEFF_BANK3 = 3'd4,
    REG_INIT_PREV   = 3'd5,
    REG_INIT_PREV2  = 3'd6
  } cfg_idx_e;

  typedef logic [COEFF_BANKS-1:0][COEFFS_PER_BANK-1:0][15:0] coeff_tab_t;

  typedef struct packed {
    logic [1:0]         fmt;
    coeff_tab_t         coeff;
    logic signed [15:0] init_prev;
    logic signed [15:0] init_prev2;
  } apbd_cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        block_start;
    logic [15:0] sample_count;
  } apbd_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_of_block;
  } apbd_out_t;

endpackage

[hdl/apbd_cfg_regs.sv]
// Configuration register file: format, predictor coefficient banks, start history.
module apbd_cfg_regs
  import apbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output apbd_cfg_t             cfg_o
);

  apbd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FORMAT:      cfg_q.fmt <= cfg_wdata_i[1:0];
        REG_COEFF_BANK0: cfg_q.coeff[0] <= cfg_wdata_i;
        REG_COEFF_BANK1: cfg_q.coeff[1] <= cfg_wdata_i;
        REG_COEFF_BANK2: cfg_q.coeff[2] <= cfg_wdata_i;
        REG_COEFF_BANK3: cfg_q.coeff[3] <= cfg_wdata_i;
        REG_INIT_PREV:   cfg_q.init_prev <= cfg_wdata_i[15:0];
        REG_INIT_PREV2:  cfg_q.init_prev2 <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/apbd_sample_calc.sv]
// One ADPCM sample: scaled nibble plus two-tap prediction, rounded and saturated.
module apbd_sample_calc
  import apbd_pkg::*;
(
  input  logic [7:0]         header_i,
  input  logic [3:0]         nibble_i,
  input  logic signed [15:0] prev_i,
  input  logic signed [15:0] prev2_i,
  input  coeff_tab_t         coeff_i,
  output logic signed [15:0] sample_o
);

  logic [3:0]            pred;
  logic [3:0]            shift;
  logic [3:0]            idx0;
  logic [3:0]            idx1;
  logic signed [15:0]    c0;
  logic signed [15:0]    c1;
  logic signed [15:0]    scale;
  logic signed [19:0]    scaled;
  logic signed [31:0]    p0;
  logic signed [31:0]    p1;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] q;

  always_comb begin
    pred  = header_i[7:4];
    shift = header_i[3:0];
    // 2*pred and 2*pred+1, clamped to the last coefficient
    idx0  = pred[3] ? 4'hf : {pred[2:0], 1'b0};
    idx1  = pred[3] ? 4'hf : {pred[2:0], 1'b1};
    c0    = coeff_i[idx0[3:2]][idx0[1:0]];
    c1    = coeff_i[idx1[3:2]][idx1[1:0]];
    // shift of 15 wraps to -32768
    scale  = 16'(16'd1 << shift);
    scaled = scale * $signed(nibble_i);
    p0     = c0 * prev_i;
    p1     = c1 * prev2_i;
    term   = {{(SUM_W-20){scaled[19]}}, scaled};
    sum    = (term <<< FRAC_BITS)
           + {{(SUM_W-32){p0[31]}}, p0}
           + {{(SUM_W-32){p1[31]}}, p1}
           + ROUND_ADD;
    q      = sum >>> FRAC_BITS;
    if (q > SAT_HI) begin
      sample_o = 16'sh7fff;
    end else if (q < SAT_LO) begin
      sample_o = -16'sh8000;
    end else begin
      sample_o = q[15:0];
    end
  end

endmodule

[hdl/adpcm_pcm_block_decoder_unit.sv]
// Top level of the PCM8 / PCM16 / 4-bit ADPCM block decoder.
// Raw block bytes enter one item at a time through an input register; a single
// decode step per cycle turns them into signed 16-bit samples held in an output
// register. PCM8 bytes, PCM16 byte pairs and ADPCM frame headers take one decode
// step per byte; an ADPCM data byte takes a decode step per nibble, because the
// low-nibble sample needs the history written by the high-nibble sample through
// the shared prediction unit (two 16x16 multipliers, sum, round, saturate).
// An accepted item waits in the input register until the decode step writes its
// first sample to the output register; the ADPCM low-nibble sample follows in the
// next step. A stalled output holds the decode step and the input register.
module adpcm_pcm_block_decoder_unit
  import apbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  apbd_in_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output apbd_out_t             out_item_o
);

  apbd_cfg_t cfg;

  apbd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  logic     in_vld_q, in_vld_d;
  apbd_in_t in_q;
  logic     nib_q, nib_d;

  // decoder state
  logic signed [15:0] prev_q, prev_d;
  logic signed [15:0] prev2_q, prev2_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [FPOS_W-1:0]  fpos_q, fpos_d;
  logic [15:0]        remain_q, remain_d;
  logic [7:0]         held_q, held_d;
  logic               phase_q, phase_d;

  // output register
  logic      out_vld_q, out_vld_d;
  apbd_out_t out_q, out_d;

  logic               out_free;
  logic               step;
  logic               done;
  logic               emit;
  logic               reload;
  logic signed [15:0] emit_sample;
  logic [15:0]        remain_dec;
  logic [FPOS_W-1:0]  fpos_inc;
  logic [3:0]         nibble;
  logic signed [15:0] calc_sample;
  logic signed [15:0] prev_cur;
  logic signed [15:0] prev2_cur;

  assign out_free = !out_vld_q || !out_stall_i;
  assign step     = in_vld_q && out_free;
  assign reload   = !nib_q && in_q.block_start;
  assign nibble   = nib_q ? in_q.data_byte[3:0] : in_q.data_byte[7:4];

  // history as it stands before this step's sample
  assign prev_cur  = reload ? cfg.init_prev  : prev_q;
  assign prev2_cur = reload ? cfg.init_prev2 : prev2_q;

  apbd_sample_calc u_calc (
    .header_i (hdr_q),
    .nibble_i (nibble),
    .prev_i   (prev_cur),
    .prev2_i  (prev2_cur),
    .coeff_i  (cfg.coeff),
    .sample_o (calc_sample)
  );

  always_comb begin
    // block start reloads history and counters before the byte is used
    prev_d   = prev_cur;
    prev2_d  = prev2_cur;
    fpos_d   = reload ? '0 : fpos_q;
    remain_d = reload ? in_q.sample_count : remain_q;
    held_d   = reload ? '0 : held_q;
    phase_d  = reload ? 1'b0 : phase_q;
    hdr_d    = hdr_q;
    nib_d    = nib_q;
    done     = 1'b1;
    emit     = 1'b0;
    emit_sample = calc_sample;

    if (nib_q) begin
      emit = 1'b1;
    end else if (remain_d != '0) begin
      case (cfg.fmt)
        FMT_PCM8: begin
          emit = 1'b1;
          emit_sample = {{8{in_q.data_byte[7]}}, in_q.data_byte};
        end
        FMT_PCM16: begin
          if (!phase_d) begin
            held_d  = in_q.data_byte;
            phase_d = 1'b1;
          end else begin
            phase_d = 1'b0;
            emit = 1'b1;
            emit_sample = {in_q.data_byte, held_d};
          end
        end
        FMT_ADPCM: begin
          if (!phase_d && fpos_d == '0) begin
            hdr_d   = in_q.data_byte;
            phase_d = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        default: ;
      endcase
    end

    remain_dec = remain_d - 16'd1;
    fpos_inc   = (fpos_d == FPOS_LAST) ? '0 : fpos_d + 1'b1;
    out_d      = out_q;

    if (emit) begin
      out_d.sample        = emit_sample;
      out_d.last_of_block = (remain_dec == '0);
      remain_d = remain_dec;
      fpos_d   = fpos_inc;
      if (cfg.fmt == FMT_ADPCM) begin
        prev2_d = prev_d;
        prev_d  = calc_sample;
        // second nibble of this byte still to go
        if (!nib_q && remain_dec != '0) begin
          nib_d = 1'b1;
          done  = 1'b0;
        end else begin
          nib_d = 1'b0;
          if (fpos_inc == '0) begin
            phase_d = 1'b0;
          end
        end
      end
    end

    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (step) begin
      out_vld_d = emit;
      if (done) begin
        in_vld_d = 1'b0;
      end
    end
    if (in_valid_i && (!in_vld_q || (step && done))) begin
      in_vld_d = 1'b1;
    end
  end

  assign in_stall_o = in_vld_q && !(step && done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      nib_q     <= 1'b0;
      out_vld_q <= 1'b0;
      prev_q    <= '0;
      prev2_q   <= '0;
      hdr_q     <= '0;
      fpos_q    <= '0;
      remain_q  <= '0;
      held_q    <= '0;
      phase_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step) begin
        nib_q    <= nib_d;
        prev_q   <= prev_d;
        prev2_q  <= prev2_d;
        hdr_q    <= hdr_d;
        fpos_q   <= fpos_d;
        remain_q <= remain_d;
        held_q   <= held_d;
        phase_q  <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (step && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_nib_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nib_q |-> in_vld_q && remain_q != '0 && cfg.fmt == FMT_ADPCM)
    else $error("second nibble pending without a live ADPCM item");

  a_fpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpos_q <= FPOS_LAST)
    else $error("frame position out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit |-> !out_vld_q || !out_stall_i)
    else $error("result written over an untaken result");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.last_of_block |-> remain_q == '0)
    else $error("last sample shown while block still has samples");

  a_nib_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nib_q && step |=> !nib_q)
    else $error("second nibble step did not finish the item");

endmodule
